@@ rtl/core/vtpd_pkg.sv @@
package vtpd_pkg;

    localparam int KIND_W       = 2;
    localparam int TIME_W       = 32;
    localparam int FREQ_W       = 9;
    localparam int PERIOD_W     = 10;
    localparam int DUTY_W       = 7;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 10;

    localparam logic [KIND_W-1:0] KIND_TICK       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PWM        = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FORCE_AUTO = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_FREQ  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD = 1'b1;

    localparam logic [FREQ_W-1:0]   AUTO_FREQ_RESET  = 9'd1;
    localparam logic [PERIOD_W-1:0] PWM_PERIOD_RESET = 10'd200;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_MIN  = 7'd13;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 7'd87;

    localparam logic [17:0] HALF_SECOND_MS = 18'd500;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TIME_W-1:0]  current_time;
        logic               trigger_level;
        logic               auto_level;
        logic signed [7:0]  throttle;
        logic               auto_request;
    } in_item_t;

    typedef struct packed {
        logic valve_open;
        logic auto_active;
    } out_item_t;

    typedef struct packed {
        logic [FREQ_W-1:0]   auto_freq;
        logic [PERIOD_W-1:0] pwm_period;
    } cfg_t;

endpackage

@@ rtl/core/valve_toggle_pwm_driver.sv @@
// valve driver with toggle, auto blink and slow pwm with limited pulse width
//
// input channel in_valid/in_ready carries one item per tick: kind, millisecond
// timestamp, sampled trigger and auto pin levels, throttle and auto request.
// output channel out_valid/out_ready returns one item per input item with the
// valve level and auto flag after that item, in input order.
// configuration: cfg_we, cfg_index, cfg_wdata; index 0 auto_freq, index 1
// pwm_period; write only while no item is in flight.
//
// an accepted item passes through one input register, then a single pass of
// state update logic into the result register, which drives out_valid.
// throughput is one item per cycle unless the receiver stalls.
// when the receiver stalls, the result register holds its item and the input
// register still takes one more item; in_ready drops only when both are full.
// reset clears the valve (closed), auto flag, pin history and both time marks,
// sets auto_freq to 1 and pwm_period to 200, and empties both registers.
module valve_toggle_pwm_driver
    import vtpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;

    logic      out_free;
    logic      advance;
    logic      in_fire;
    cfg_t      cfg;
    out_item_t result;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_item_reg <= in_item;
        if (advance)
            out_item_reg <= result;
    end

    vtpd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vtpd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ rtl/core/vtpd_cfg.sv @@
module vtpd_cfg
    import vtpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    logic [FREQ_W-1:0]   auto_freq_reg;
    logic [FREQ_W-1:0]   auto_freq_next;
    logic [PERIOD_W-1:0] pwm_period_reg;
    logic [PERIOD_W-1:0] pwm_period_next;

    always_comb
    begin
        auto_freq_next  = auto_freq_reg;
        pwm_period_next = pwm_period_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_AUTO_FREQ:  auto_freq_next  = cfg_wdata[FREQ_W-1:0];
                CFG_PWM_PERIOD: pwm_period_next = cfg_wdata[PERIOD_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_freq_reg  <= AUTO_FREQ_RESET;
            pwm_period_reg <= PWM_PERIOD_RESET;
        end
        else
        begin
            auto_freq_reg  <= auto_freq_next;
            pwm_period_reg <= pwm_period_next;
        end
    end

    assign cfg.auto_freq  = auto_freq_reg;
    assign cfg.pwm_period = pwm_period_reg;

endmodule

@@ rtl/core/vtpd_core.sv @@
module vtpd_core
    import vtpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic              valve_state_reg;
    logic              valve_state_next;
    logic              auto_state_reg;
    logic              auto_state_next;
    logic              last_trigger_reg;
    logic              last_trigger_next;
    logic              last_auto_pin_reg;
    logic              last_auto_pin_next;
    logic [TIME_W-1:0] last_toggle_time_reg;
    logic [TIME_W-1:0] last_toggle_time_next;
    logic [TIME_W-1:0] window_start_reg;
    logic [TIME_W-1:0] window_start_next;

    logic [FREQ_W-1:0] freq_eff;
    logic [TIME_W-1:0] dt_toggle;
    logic [17:0]       auto_prod;
    logic              auto_expired;

    logic [DUTY_W-1:0] duty;
    logic [TIME_W-1:0] dt_window;
    logic [16:0]       on_prod;
    logic [10:0]       dt_plus_one;
    logic [16:0]       dt_scaled;
    logic              dt_lt_on;
    logic              dt_lt_period;

    logic              valve_mid;
    logic              auto_mid;

    // auto interval test: dt > 500/f is the same as dt*f > 500
    assign freq_eff     = (cfg.auto_freq == '0) ? 9'd1 : cfg.auto_freq;
    assign dt_toggle    = item.current_time - last_toggle_time_reg;
    assign auto_prod    = 18'(dt_toggle[8:0]) * 18'(freq_eff);
    assign auto_expired = (dt_toggle[TIME_W-1:9] != '0) || (auto_prod > HALF_SECOND_MS);

    always_comb
    begin
        if (item.throttle[7])
            duty = '0;
        else if (item.throttle[6:0] > DUTY_FULL)
            duty = DUTY_FULL;
        else
            duty = item.throttle[6:0];
        if (duty != '0 && duty != DUTY_FULL)
        begin
            if (duty < DUTY_MIN)
                duty = DUTY_MIN;
            else if (duty > DUTY_MAX)
                duty = DUTY_MAX;
        end
    end

    // dt < period*duty/100 is the same as 100*(dt+1) <= period*duty
    assign dt_window    = item.current_time - window_start_reg;
    assign on_prod      = 17'(cfg.pwm_period) * 17'(duty);
    assign dt_plus_one  = 11'(dt_window[9:0]) + 11'd1;
    assign dt_scaled    = 17'(dt_plus_one) * 17'(DUTY_FULL);
    assign dt_lt_on     = (dt_window[TIME_W-1:10] == '0) && (dt_scaled <= on_prod);
    assign dt_lt_period = dt_window < TIME_W'(cfg.pwm_period);

    always_comb
    begin
        valve_state_next      = valve_state_reg;
        auto_state_next       = auto_state_reg;
        last_trigger_next     = last_trigger_reg;
        last_auto_pin_next    = last_auto_pin_reg;
        last_toggle_time_next = last_toggle_time_reg;
        window_start_next     = window_start_reg;
        valve_mid             = valve_state_reg;
        auto_mid              = auto_state_reg;
        case (item.kind)
            KIND_TICK:
            begin
                if (item.trigger_level && !last_trigger_reg)
                    valve_mid = !valve_state_reg;
                if (item.auto_level && !last_auto_pin_reg)
                    auto_mid = !auto_state_reg;
                last_trigger_next  = item.trigger_level;
                last_auto_pin_next = item.auto_level;
                auto_state_next    = auto_mid;
                valve_state_next   = valve_mid;
                if (auto_mid && auto_expired)
                begin
                    valve_state_next      = !valve_mid;
                    last_toggle_time_next = item.current_time;
                end
            end
            KIND_PWM:
            begin
                if (duty == '0 && valve_state_reg)
                    valve_state_next = 1'b0;
                else if (duty == DUTY_FULL)
                    valve_state_next = 1'b1;
                else if (dt_lt_on)
                    valve_state_next = 1'b1;
                else if (dt_lt_period)
                    valve_state_next = 1'b0;
                else
                    window_start_next = item.current_time;
            end
            KIND_FORCE_AUTO:
            begin
                auto_state_next = item.auto_request;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valve_state_reg      <= 1'b0;
            auto_state_reg       <= 1'b0;
            last_trigger_reg     <= 1'b0;
            last_auto_pin_reg    <= 1'b0;
            last_toggle_time_reg <= '0;
            window_start_reg     <= '0;
        end
        else if (advance)
        begin
            valve_state_reg      <= valve_state_next;
            auto_state_reg       <= auto_state_next;
            last_trigger_reg     <= last_trigger_next;
            last_auto_pin_reg    <= last_auto_pin_next;
            last_toggle_time_reg <= last_toggle_time_next;
            window_start_reg     <= window_start_next;
        end
    end

    assign result.valve_open  = valve_state_next;
    assign result.auto_active = auto_state_next;

`ifndef ASSERT_OFF
    a_force_auto: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.kind == KIND_FORCE_AUTO |=> auto_state_reg == $past(item.auto_request))
        else $error("force auto item did not set the auto flag");

    a_full_duty: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.kind == KIND_PWM && !item.throttle[7] && item.throttle[6:0] >= DUTY_FULL
        |=> valve_state_reg)
        else $error("full throttle did not open the valve");

    a_pwm_keeps_auto: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.kind == KIND_PWM
        |=> auto_state_reg == $past(auto_state_reg) && $stable(last_trigger_reg))
        else $error("pwm item disturbed auto state or pin history");

    a_tick_keeps_window: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.kind == KIND_TICK |=> $stable(window_start_reg))
        else $error("tick item moved the pwm window");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable({valve_state_reg, auto_state_reg, last_toggle_time_reg}))
        else $error("state changed without an item");
`endif

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import vtpd_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned PHASES = 7;
    localparam int unsigned ITEMS_PER_PHASE = 255;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_item;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predicted block state and register copies
    logic [FREQ_W-1:0] auto_freq_q = AUTO_FREQ_RESET;
    logic [PERIOD_W-1:0] pwm_period_q = PWM_PERIOD_RESET;
    logic valve_q = 1'b0;
    logic auto_q = 1'b0;
    logic trig_hist_q = 1'b0;
    logic apin_hist_q = 1'b0;
    logic [TIME_W-1:0] toggle_time_q = '0;
    logic [TIME_W-1:0] window_start_q = '0;

    in_item_t pending_items[$];
    out_item_t expected_levels[$];
    out_item_t want_levels;
    int unsigned items_queued = 0;
    int unsigned items_checked = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 1;
    int unsigned ready_pct = 100;
    int unsigned ready_hold = 0;

    // random stimulus history
    logic [TIME_W-1:0] now_ms = '0;
    logic trig_pin = 1'b0;
    logic auto_pin = 1'b0;

    int unsigned phase_freq [PHASES] = '{1, 500, 0, 511, 7, 100, 3};
    int unsigned phase_period [PHASES] = '{200, 1000, 2, 1, 0, 1023, 150};
    int unsigned phase_step [PHASES] = '{40, 60, 3, 2, 5, 80, 30};

    valve_toggle_pwm_driver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic out_item_t predict_levels(in_item_t it);
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] blink_interval;
        logic [TIME_W-1:0] on_time;
        int duty;
        out_item_t res;
        case (it.kind)
            KIND_TICK:
            begin
                if (it.trigger_level && !trig_hist_q)
                    valve_q = ~valve_q;
                trig_hist_q = it.trigger_level;
                if (it.auto_level && !apin_hist_q)
                    auto_q = ~auto_q;
                apin_hist_q = it.auto_level;
                // a rate of zero counts as one
                blink_interval = 32'd500 / ((auto_freq_q == '0) ? 32'd1 : 32'(auto_freq_q));
                elapsed = it.current_time - toggle_time_q;
                if (auto_q && elapsed > blink_interval)
                begin
                    valve_q = ~valve_q;
                    toggle_time_q = it.current_time;
                end
            end
            KIND_PWM:
            begin
                duty = int'($signed(it.throttle));
                if (duty < 0)
                    duty = 0;
                if (duty > 100)
                    duty = 100;
                if (duty > 0 && duty < 100)
                begin
                    if (duty < 13)
                        duty = 13;
                    if (duty > 87)
                        duty = 87;
                end
                on_time = 32'(pwm_period_q) * 32'(duty) / 32'd100;
                elapsed = it.current_time - window_start_q;
                if (duty == 0 && valve_q)
                    valve_q = 1'b0;
                else if (duty == 100)
                    valve_q = 1'b1;
                else if (elapsed < on_time)
                    valve_q = 1'b1;
                else if (elapsed < 32'(pwm_period_q))
                    valve_q = 1'b0;
                else
                    window_start_q = it.current_time;
            end
            KIND_FORCE_AUTO:
                auto_q = it.auto_request;
            default:
                ;
        endcase
        res.valve_open = valve_q;
        res.auto_active = auto_q;
        return res;
    endfunction

    function automatic in_item_t make_item(logic [KIND_W-1:0] k, logic [TIME_W-1:0] t,
                                           logic trig, logic apin,
                                           logic signed [7:0] thr, logic req);
        in_item_t it;
        it.kind = k;
        it.current_time = t;
        it.trigger_level = trig;
        it.auto_level = apin;
        it.throttle = thr;
        it.auto_request = req;
        return it;
    endfunction

    function automatic in_item_t random_item(int unsigned step_max);
        in_item_t it;
        int unsigned pick;
        pick = $urandom_range(0, 199);
        if (pick == 0)
            now_ms = $urandom();
        else if (pick == 1)
            now_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * step_max);
        else
            now_ms = now_ms + $urandom_range(0, step_max);
        if ($urandom_range(0, 9) < 3)
            trig_pin = ~trig_pin;
        if ($urandom_range(0, 19) < 3)
            auto_pin = ~auto_pin;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.kind = KIND_TICK;
        else if (pick < 85)
            it.kind = KIND_PWM;
        else if (pick < 93)
            it.kind = KIND_FORCE_AUTO;
        else
            it.kind = KIND_UNUSED;
        it.current_time = now_ms;
        it.trigger_level = trig_pin;
        it.auto_level = auto_pin;
        case ($urandom_range(0, 9))
            0: it.throttle = 8'sd0;
            1: it.throttle = 8'sd100;
            2: it.throttle = 8'($urandom_range(1, 12));
            3: it.throttle = 8'($urandom_range(88, 99));
            4: it.throttle = $urandom_range(0, 1) ? 8'sd13 : 8'sd87;
            5: it.throttle = 8'($urandom_range(128, 255));
            6: it.throttle = 8'($urandom_range(101, 127));
            default: it.throttle = 8'($urandom_range(0, 100));
        endcase
        it.auto_request = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic queue_item(in_item_t it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic wait_all_results();
        while (items_checked != items_queued)
            @(posedge clk);
    endtask

    task automatic program_regs(logic [FREQ_W-1:0] freq, logic [PERIOD_W-1:0] period);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_AUTO_FREQ;
        cfg_wdata <= {($urandom_range(0, 1) != 0), freq};
        @(posedge clk);
        cfg_index <= CFG_PWM_PERIOD;
        cfg_wdata <= period;
        @(posedge clk);
        cfg_we <= 1'b0;
        auto_freq_q = freq;
        pwm_period_q = period;
    endtask

    // item driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_levels.push_back(predict_levels(in_item));
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0 || pending_items.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                end
                else
                begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
            end
        end
    end

    // result monitor, receiver stalls and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_levels.size() == 0)
                begin
                    $error("result item with no item outstanding");
                    mismatches++;
                end
                else
                begin
                    want_levels = expected_levels.pop_front();
                    if (out_item.valve_open !== want_levels.valve_open)
                    begin
                        $error("valve_open expected %0b actual %0b",
                               want_levels.valve_open, out_item.valve_open);
                        mismatches++;
                    end
                    if (out_item.auto_active !== want_levels.auto_active)
                    begin
                        $error("auto_active expected %0b actual %0b",
                               want_levels.auto_active, out_item.auto_active);
                        mismatches++;
                    end
                    items_checked++;
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            if (ready_hold == 0)
            begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 85;
                    2: ready_pct = 50;
                    default: ready_pct = 20;
                endcase
                ready_hold = $urandom_range(64, 200);
            end
            else
                ready_hold--;
            out_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            program_regs(FREQ_W'(phase_freq[p]), PERIOD_W'(phase_period[p]));
            if (p == 0)
            begin
                queue_item(make_item(KIND_UNUSED, 32'd0, 1'b0, 1'b0, 8'sd0, 1'b0));
                queue_item(make_item(KIND_TICK, 32'd10, 1'b1, 1'b0, 8'sd0, 1'b0));
                queue_item(make_item(KIND_TICK, 32'd20, 1'b1, 1'b0, 8'sd0, 1'b0));
                queue_item(make_item(KIND_TICK, 32'd30, 1'b0, 1'b1, 8'sd0, 1'b0));
                queue_item(make_item(KIND_TICK, 32'd531, 1'b0, 1'b1, 8'sd0, 1'b0));
                queue_item(make_item(KIND_TICK, 32'd600, 1'b0, 1'b0, 8'sd0, 1'b0));
                queue_item(make_item(KIND_TICK, 32'd1032, 1'b0, 1'b0, 8'sd0, 1'b0));
                queue_item(make_item(KIND_FORCE_AUTO, 32'd1040, 1'b1, 1'b1, 8'sd0, 1'b0));
                queue_item(make_item(KIND_FORCE_AUTO, 32'd1050, 1'b0, 1'b0, 8'sd0, 1'b1));
                queue_item(make_item(KIND_PWM, 32'd1100, 1'b0, 1'b0, 8'sd100, 1'b0));
                queue_item(make_item(KIND_PWM, 32'd1110, 1'b0, 1'b0, 8'sd0, 1'b0));
                // zero throttle with the valve already shut goes through the window
                queue_item(make_item(KIND_PWM, 32'd1120, 1'b0, 1'b0, 8'sd0, 1'b0));
                queue_item(make_item(KIND_PWM, 32'd1130, 1'b0, 1'b0, -8'sd128, 1'b0));
                queue_item(make_item(KIND_PWM, 32'd1140, 1'b0, 1'b0, 8'sd127, 1'b0));
                queue_item(make_item(KIND_PWM, 32'd1150, 1'b0, 1'b0, 8'sd5, 1'b0));
                queue_item(make_item(KIND_PWM, 32'd1300, 1'b0, 1'b0, 8'sd95, 1'b0));
                queue_item(make_item(KIND_PWM, 32'd1330, 1'b0, 1'b0, 8'sd13, 1'b0));
                queue_item(make_item(KIND_PWM, 32'd1335, 1'b0, 1'b0, 8'sd87, 1'b0));
                queue_item(make_item(KIND_PWM, 32'd1400, 1'b0, 1'b0, 8'sd50, 1'b0));
                queue_item(make_item(KIND_TICK, 32'hFFFF_FFF0, 1'b1, 1'b0, -8'sd1, 1'b1));
                queue_item(make_item(KIND_TICK, 32'h0000_0010, 1'b0, 1'b1, 8'sd0, 1'b0));
                queue_item(make_item(KIND_TICK, 32'h0000_0300, 1'b0, 1'b1, 8'sd0, 1'b0));
                queue_item(make_item(KIND_PWM, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'sd1, 1'b1));
                queue_item(make_item(KIND_UNUSED, 32'd123, 1'b1, 1'b1, -8'sd100, 1'b1));
                queue_item(make_item(KIND_FORCE_AUTO, 32'd0, 1'b0, 1'b0, 8'sd0, 1'b0));
                now_ms = 32'd1400;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_item(random_item(phase_step[p]));
            wait_all_results();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_levels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ valve_toggle_pwm_driver.f @@
rtl/core/vtpd_pkg.sv
rtl/core/vtpd_cfg.sv
rtl/core/vtpd_core.sv
rtl/core/valve_toggle_pwm_driver.sv
tb/sv/tb.sv
